// File: rtl/core/circle_ring_fill_pixel_classifier_core_macros.svh
`ifndef CIRCLE_RING_FILL_PIXEL_CLASSIFIER_CORE_MACROS_SVH
`define CIRCLE_RING_FILL_PIXEL_CLASSIFIER_CORE_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CRFPC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("crfpc check failed");

// Condition that must never be seen outside reset.
`define CRFPC_ASSERT_NEVER(label, cond) \
  `CRFPC_ASSERT_IMPLY(label, 1'b1, !(cond))

`endif

// File: rtl/core/crfpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crfpc_pkg;

  localparam int COORD_W         = 12;
  localparam int COLOR_W         = 24;
  localparam int DIM_W           = 13;
  localparam int DIST_W          = 25;
  localparam int ROOT_W          = 13;
  localparam int TRIAL_W         = 27;
  localparam int CFG_IDX_W       = 4;
  localparam int CFG_DATA_W      = 32;
  localparam int MAX_DIM_DEFAULT = 4096;
  // accepting edge to the edge that takes the result
  localparam int LATENCY         = 18;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [COLOR_W-1:0]  color_t;
  typedef logic [DIM_W-1:0]    dim_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [ROOT_W-1:0]   root_t;
  typedef logic [TRIAL_W-1:0]  trial_t;
  typedef logic [2*COORD_W-1:0] square_t;

  localparam logic [7:0] COMPONENT_MAX = 8'd255;
  localparam color_t     COLOR_MASK    = {COMPONENT_MAX, COMPONENT_MAX, COMPONENT_MAX};

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CIRCLE_RADIUS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTH    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLINE_COLOR = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_SETTING  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd7;

  localparam logic [1:0] PAINT_NONE    = 2'd0;
  localparam logic [1:0] PAINT_OUTLINE = 2'd1;
  localparam logic [1:0] PAINT_FILL    = 2'd2;

  localparam int FILL_EN_BIT = 24;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
  } pixel_req_t;

  typedef struct packed {
    color_t     new_color;
    logic [1:0] paint_kind;
  } pixel_res_t;

  // settings as the pipeline sees them
  typedef struct packed {
    logic    draw_ok;
    coord_t  cx;
    coord_t  cy;
    coord_t  radius;
    dim_t    ring_lo;
    square_t radius_sq;
    dim_t    w_lim;
    dim_t    h_lim;
    color_t  outline_color;
    logic    fill_en;
    color_t  fill_color;
  } cfg_view_t;

  // one pixel moving down the square root chain
  typedef struct packed {
    logic   valid;
    logic   draw;
    color_t color;
    dist_t  sq_dist;
    dist_t  nbr;
    dist_t  rem;
    root_t  root;
  } root_lane_t;

endpackage

`default_nettype wire

// File: rtl/core/circle_ring_fill_pixel_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted request passes through four front stages, 13 square root cells
//   and one output stage, which raises the result strobe.
// Throughput: one pixel per clock; busy is low whenever reset is released.
// Reset: synchronous, active low; clears the pipeline and loads register defaults
//   (image size 4096 by 4096, all else zero). Results cannot be held off by the receiver.
module circle_ring_fill_pixel_classifier_core #(
  parameter int MAX_DIM = crfpc_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire crfpc_pkg::pixel_req_t             in_pixel,
  output logic                                   out_strobe,
  output crfpc_pkg::pixel_res_t                  out_result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [crfpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crfpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  crfpc_pkg::cfg_view_t  view;
  crfpc_pkg::root_lane_t lane [0:crfpc_pkg::ROOT_W];
  crfpc_pkg::root_lane_t last;

  logic                  out_strobe_r;
  crfpc_pkg::pixel_res_t out_result_r, out_result_nxt;

  crfpc_pkg::root_t  radius_w, k;
  crfpc_pkg::dist_t  k_sq, radius_sq_w;
  logic              outline_hit, fill_hit;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;

  crfpc_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .view     (view)
  );

  crfpc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (start & ~busy),
    .req       (in_pixel),
    .view      (view),
    .lane_out  (lane[0])
  );

  // one root bit per cell, most significant first
  for (genvar i = 0; i < crfpc_pkg::ROOT_W; i++) begin : g_cell
    crfpc_root_cell #(
      .BIT (crfpc_pkg::ROOT_W - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_in  (lane[i]),
      .lane_out (lane[i+1])
    );
  end

  assign last = lane[crfpc_pkg::ROOT_W];

  always_comb begin
    radius_w    = {1'b0, view.radius};
    radius_sq_w = {1'b0, view.radius_sq};
    // largest candidate ring is min(isqrt(d), radius); its square is d - rem below radius
    if (last.root > radius_w) begin
      k    = radius_w;
      k_sq = radius_sq_w;
    end else begin
      k    = last.root;
      k_sq = last.sq_dist - last.rem;
    end
    outline_hit = last.draw && (k >= view.ring_lo) && (k_sq > last.nbr);
    fill_hit    = last.draw && view.fill_en && (last.sq_dist < radius_sq_w);

    if (outline_hit) begin
      out_result_nxt.new_color  = view.outline_color;
      out_result_nxt.paint_kind = crfpc_pkg::PAINT_OUTLINE;
    end else if (fill_hit) begin
      out_result_nxt.new_color  = view.fill_color;
      out_result_nxt.paint_kind = crfpc_pkg::PAINT_FILL;
    end else begin
      out_result_nxt.new_color  = last.color;
      out_result_nxt.paint_kind = crfpc_pkg::PAINT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

// File: rtl/core/crfpc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module crfpc_cfg #(
  parameter int MAX_DIM = crfpc_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                wr_en,
  input  wire logic [crfpc_pkg::CFG_IDX_W-1:0]     wr_index,
  input  wire logic [crfpc_pkg::CFG_DATA_W-1:0]    wr_data,
  output crfpc_pkg::cfg_view_t                     view
);

  // image size registers are 13 bits, so a cap above their range never bites
  localparam int            DimCap  = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam crfpc_pkg::dim_t DIM_CAP = crfpc_pkg::dim_t'(DimCap);

  crfpc_pkg::coord_t cx_r, cy_r, radius_r, ring_w_r;
  crfpc_pkg::color_t outline_r;
  logic [24:0]       fill_r;
  crfpc_pkg::dim_t   img_w_r, img_h_r;

  crfpc_pkg::cfg_view_t view_r, view_nxt;
  crfpc_pkg::dim_t      w_lim, h_lim, cx_end, cy_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= '0;
      cy_r      <= '0;
      radius_r  <= '0;
      ring_w_r  <= '0;
      outline_r <= '0;
      fill_r    <= '0;
      img_w_r   <= crfpc_pkg::dim_t'(4096);
      img_h_r   <= crfpc_pkg::dim_t'(4096);
    end else if (wr_en) begin
      unique case (wr_index)
        crfpc_pkg::REG_CENTER_X:      cx_r      <= wr_data[11:0];
        crfpc_pkg::REG_CENTER_Y:      cy_r      <= wr_data[11:0];
        crfpc_pkg::REG_CIRCLE_RADIUS: radius_r  <= wr_data[11:0];
        crfpc_pkg::REG_RING_WIDTH:    ring_w_r  <= wr_data[11:0];
        crfpc_pkg::REG_OUTLINE_COLOR: outline_r <= wr_data[23:0];
        crfpc_pkg::REG_FILL_SETTING:  fill_r    <= wr_data[24:0];
        crfpc_pkg::REG_IMAGE_WIDTH:   img_w_r   <= wr_data[12:0];
        crfpc_pkg::REG_IMAGE_HEIGHT:  img_h_r   <= wr_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_lim  = (img_w_r > DIM_CAP) ? DIM_CAP : img_w_r;
    h_lim  = (img_h_r > DIM_CAP) ? DIM_CAP : img_h_r;
    cx_end = {1'b0, cx_r} + {1'b0, radius_r};
    cy_end = {1'b0, cy_r} + {1'b0, radius_r};

    view_nxt.draw_ok = ({1'b0, cx_r} < w_lim) && ({1'b0, cy_r} < h_lim) &&
                       (cx_end < w_lim) && (cy_end < h_lim) &&
                       (ring_w_r <= radius_r) && (ring_w_r != '0);
    view_nxt.cx            = cx_r;
    view_nxt.cy            = cy_r;
    view_nxt.radius        = radius_r;
    view_nxt.ring_lo       = {1'b0, radius_r} - {1'b0, ring_w_r} + crfpc_pkg::dim_t'(1);
    view_nxt.radius_sq     = {12'd0, radius_r} * {12'd0, radius_r};
    view_nxt.w_lim         = w_lim;
    view_nxt.h_lim         = h_lim;
    view_nxt.outline_color = outline_r & crfpc_pkg::COLOR_MASK;
    view_nxt.fill_en       = fill_r[crfpc_pkg::FILL_EN_BIT];
    view_nxt.fill_color    = fill_r[23:0] & crfpc_pkg::COLOR_MASK;
  end

  // registered; users must change settings only while idle, not checked here
  always_ff @(posedge clk) begin
    view_r <= view_nxt;
  end

  assign view = view_r;

endmodule

`default_nettype wire

// File: rtl/core/crfpc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module crfpc_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  req_valid,
  input  wire crfpc_pkg::pixel_req_t req,
  input  wire crfpc_pkg::cfg_view_t  view,
  output crfpc_pkg::root_lane_t      lane_out
);

  // capture
  logic                  s1_v_r;
  crfpc_pkg::pixel_req_t s1_req_r;

  // offsets and region test
  logic              s2_v_r, s2_draw_r, s2_draw_nxt;
  crfpc_pkg::color_t s2_color_r;
  crfpc_pkg::coord_t s2_adx_r, s2_ady_r, s2_nx_r, s2_ny_r;
  crfpc_pkg::coord_t adx, ady;

  // squares
  logic               s3_v_r, s3_draw_r;
  crfpc_pkg::color_t  s3_color_r;
  crfpc_pkg::square_t s3_dx2_r, s3_dy2_r, s3_nx2_r, s3_ny2_r;

  // sums
  logic              s4_v_r, s4_draw_r;
  crfpc_pkg::color_t s4_color_r;
  crfpc_pkg::dist_t  s4_dist_r, s4_nbr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= req_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_comb begin
    adx = (s1_req_r.pixel_x >= view.cx) ? s1_req_r.pixel_x - view.cx
                                        : view.cx - s1_req_r.pixel_x;
    ady = (s1_req_r.pixel_y >= view.cy) ? s1_req_r.pixel_y - view.cy
                                        : view.cy - s1_req_r.pixel_y;
    s2_draw_nxt = view.draw_ok &&
                  ({1'b0, s1_req_r.pixel_x} < view.w_lim) &&
                  ({1'b0, s1_req_r.pixel_y} < view.h_lim) &&
                  (adx <= view.radius) && (ady <= view.radius);
  end

  always_ff @(posedge clk) begin
    s1_req_r <= req;

    s2_draw_r  <= s2_draw_nxt;
    s2_color_r <= s1_req_r.pixel_color;
    s2_adx_r   <= adx;
    s2_ady_r   <= ady;
    // neighbor toward the center; on an axis the term counts as one
    s2_nx_r    <= (adx == '0) ? crfpc_pkg::coord_t'(1) : adx - crfpc_pkg::coord_t'(1);
    s2_ny_r    <= (ady == '0) ? crfpc_pkg::coord_t'(1) : ady - crfpc_pkg::coord_t'(1);

    s3_draw_r  <= s2_draw_r;
    s3_color_r <= s2_color_r;
    s3_dx2_r   <= {12'd0, s2_adx_r} * {12'd0, s2_adx_r};
    s3_dy2_r   <= {12'd0, s2_ady_r} * {12'd0, s2_ady_r};
    s3_nx2_r   <= {12'd0, s2_nx_r} * {12'd0, s2_nx_r};
    s3_ny2_r   <= {12'd0, s2_ny_r} * {12'd0, s2_ny_r};

    s4_draw_r  <= s3_draw_r;
    s4_color_r <= s3_color_r;
    s4_dist_r  <= {1'b0, s3_dx2_r} + {1'b0, s3_dy2_r};
    s4_nbr_r   <= {1'b0, s3_nx2_r} + {1'b0, s3_ny2_r};
  end

  always_comb begin
    lane_out.valid   = s4_v_r;
    lane_out.draw    = s4_draw_r;
    lane_out.color   = s4_color_r;
    lane_out.sq_dist = s4_dist_r;
    lane_out.nbr     = s4_nbr_r;
    lane_out.rem     = s4_dist_r;
    lane_out.root    = '0;
  end

endmodule

`default_nettype wire

// File: rtl/core/crfpc_root_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module crfpc_root_cell #(
  parameter int BIT = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire crfpc_pkg::root_lane_t lane_in,
  output crfpc_pkg::root_lane_t      lane_out
);

  crfpc_pkg::root_lane_t lane_r, lane_nxt;
  crfpc_pkg::trial_t     trial;

  // (root + 2^BIT)^2 - root^2, with root holding only bits above BIT
  always_comb begin
    trial    = (crfpc_pkg::trial_t'(lane_in.root) << (BIT + 1)) |
               (crfpc_pkg::trial_t'(1) << (2 * BIT));
    lane_nxt = lane_in;
    if ({2'b00, lane_in.rem} >= trial) begin
      lane_nxt.rem  = lane_in.rem - trial[crfpc_pkg::DIST_W-1:0];
      lane_nxt.root = lane_in.root | (crfpc_pkg::root_t'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_out = lane_r;

endmodule

`default_nettype wire

// File: rtl/core/crfpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "circle_ring_fill_pixel_classifier_core_macros.svh"

module crfpc_checker (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  start,
  input wire logic                  busy,
  input wire crfpc_pkg::pixel_req_t in_pixel,
  input wire logic                  out_strobe,
  input wire crfpc_pkg::pixel_res_t out_result
);

  logic              accepted;
  logic              untouched;
  crfpc_pkg::color_t in_color;

  assign accepted  = start && !busy;
  assign untouched = out_strobe && (out_result.paint_kind == crfpc_pkg::PAINT_NONE);
  assign in_color  = in_pixel.pixel_color;

  // every request comes back after the fixed pipeline delay
  `CRFPC_ASSERT_IMPLY(a_result_follows, accepted, ##(crfpc_pkg::LATENCY) out_strobe)
  // no strobe without a request that delay earlier
  `CRFPC_ASSERT_IMPLY(a_no_extra_result, out_strobe, $past(accepted, crfpc_pkg::LATENCY))
  `CRFPC_ASSERT_IMPLY(a_kind_legal, out_strobe, out_result.paint_kind <= crfpc_pkg::PAINT_FILL)
  // an untouched pixel keeps the color it came in with
  `CRFPC_ASSERT_IMPLY(a_pass_color, untouched, out_result.new_color == $past(in_color, crfpc_pkg::LATENCY))

endmodule

bind circle_ring_fill_pixel_classifier_core crfpc_checker u_crfpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_pixel   (in_pixel),
  .out_strobe (out_strobe),
  .out_result (out_result)
);

`default_nettype wire
